// ----- rtl/hsvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Types and constants shared by the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  typedef logic [8:0]  hue_t;
  typedef logic [7:0]  chan_t;
  typedef logic [5:0]  dist_t;
  typedef logic [13:0] sdist_t;
  typedef logic [21:0] mid_num_t;

  // 60-degree hue sectors, named by the colour at their start
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_e;

  localparam hue_t   HueTurn   = 9'd360;
  localparam hue_t   SectorDeg = 9'd60;
  localparam chan_t  FullScale = 8'd255;
  localparam sdist_t XDenom    = 14'd15300;

  // floor(n / 15300) == (n * MidRecip) >> MidShift for every n below 2^22
  localparam logic [22:0] MidRecip = 23'd4491470;
  localparam int unsigned MidShift = 36;

endpackage

// ----- rtl/hsvrgb_if.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_hsv_if / hsvrgb_rgb_if
// Valid/ready channels carrying one HSV colour and one RGB colour.
// ----------------------------------------------------------------------------
interface hsvrgb_hsv_if;
  import hsvrgb_pkg::*;

  logic  valid;
  logic  ready;
  hue_t  hue;
  chan_t saturation;
  chan_t brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsvrgb_rgb_if;
  import hsvrgb_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- rtl/hsvrgb_mid_div.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_mid_div
// Divides the intermediate-channel numerator by 15300 with a reciprocal
// multiply; exact over the whole 22-bit numerator range.
// ----------------------------------------------------------------------------
module hsvrgb_mid_div (
  input  hsvrgb_pkg::mid_num_t num_i,
  output hsvrgb_pkg::chan_t    quot_o
);
  import hsvrgb_pkg::*;

  logic [44:0] prod;

  assign prod   = 45'(num_i) * 45'(MidRecip);
  // quotient never exceeds 255
  assign quot_o = prod[MidShift +: 8];

endmodule

// ----- rtl/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Four-stage pipelined HSV to 8-bit RGB colour converter.
// ----------------------------------------------------------------------------
// Takes one colour per clock while its results are taken; the result
// sits in an output register, so a new colour is accepted while an earlier
// result waits. Stage one wraps the hue and finds its sector, stage two forms
// the saturation products, stage three the brightness products and the
// minimum channel, stage four the reciprocal divide for the intermediate
// channel and the sector routing. Each stage holds when the one after it is
// full and stalled, so bubbles close up and nothing is lost or repeated.
// Hue is taken modulo 360; saturation and brightness are fractions of 255.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic              clk_i,
  input  logic              rst_ni,
  hsvrgb_hsv_if.sink        hsv_i,
  hsvrgb_rgb_if.source      rgb_o
);
  import hsvrgb_pkg::*;

  // ---------------------------------------------------------------- control
  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdyo;

  assign rdyo        = !vo_q || rgb_o.ready;
  assign rdy3        = !v3_q || rdyo;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign hsv_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= hsv_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------- stage 1
  hue_t    hue_w;
  hue_t    base_w;
  sector_e sec_w;
  dist_t   ofs_w;
  dist_t   dist_w;

  always_comb begin
    hue_w = (hsv_i.hue >= HueTurn) ? hsv_i.hue - HueTurn : hsv_i.hue;
    priority if (hue_w < SectorDeg) begin
      sec_w  = SEC_RED;
      base_w = 9'd0;
    end else if (hue_w < 9'(2 * SectorDeg)) begin
      sec_w  = SEC_YELLOW;
      base_w = SectorDeg;
    end else if (hue_w < 9'(3 * SectorDeg)) begin
      sec_w  = SEC_GREEN;
      base_w = 9'(2 * SectorDeg);
    end else if (hue_w < 9'(4 * SectorDeg)) begin
      sec_w  = SEC_CYAN;
      base_w = 9'(3 * SectorDeg);
    end else if (hue_w < 9'(5 * SectorDeg)) begin
      sec_w  = SEC_BLUE;
      base_w = 9'(4 * SectorDeg);
    end else begin
      sec_w  = SEC_MAGENTA;
      base_w = 9'(5 * SectorDeg);
    end
    ofs_w = 6'(hue_w - base_w);
    // distance from the sector pair's midpoint: falling in even, rising in odd
    dist_w = sec_w[0] ? ofs_w : 6'(SectorDeg) - ofs_w;
  end

  sector_e sec1_q;
  dist_t   dist1_q;
  chan_t   sat1_q, val1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && hsv_i.valid) begin
      sec1_q  <= sec_w;
      dist1_q <= dist_w;
      sat1_q  <= hsv_i.saturation;
      val1_q  <= hsv_i.brightness;
    end
  end

  // ---------------------------------------------------------------- stage 2
  sector_e      sec2_q;
  chan_t        val2_q;
  sdist_t       sd2_q;
  logic [15:0]  lo_prod2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      sec2_q     <= sec1_q;
      val2_q     <= val1_q;
      sd2_q      <= 14'(sat1_q * dist1_q);
      lo_prod2_q <= 16'(val1_q * (FullScale - sat1_q));
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [16:0] lo_sum_w;
  sdist_t      xfac_w;

  // floor(n / 255) for any 16-bit n below 65535
  assign lo_sum_w = 17'(lo_prod2_q) + 17'(lo_prod2_q[15:8]) + 17'd1;
  assign xfac_w   = XDenom - sd2_q;

  sector_e  sec3_q;
  chan_t    val3_q;
  chan_t    lo3_q;
  mid_num_t num3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      sec3_q <= sec2_q;
      val3_q <= val2_q;
      lo3_q  <= 8'(lo_sum_w >> 8);
      num3_q <= 22'(val2_q * xfac_w);
    end
  end

  // ---------------------------------------------------------------- stage 4
  chan_t mid_w;
  chan_t red_w, green_w, blue_w;

  hsvrgb_mid_div u_mid_div (
    .num_i  (num3_q),
    .quot_o (mid_w)
  );

  always_comb begin
    unique case (sec3_q)
      SEC_RED:     begin red_w = val3_q; green_w = mid_w;  blue_w = lo3_q;  end
      SEC_YELLOW:  begin red_w = mid_w;  green_w = val3_q; blue_w = lo3_q;  end
      SEC_GREEN:   begin red_w = lo3_q;  green_w = val3_q; blue_w = mid_w;  end
      SEC_CYAN:    begin red_w = lo3_q;  green_w = mid_w;  blue_w = val3_q; end
      SEC_BLUE:    begin red_w = mid_w;  green_w = lo3_q;  blue_w = val3_q; end
      default:     begin red_w = val3_q; green_w = lo3_q;  blue_w = mid_w;  end
    endcase
  end

  chan_t red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (rdyo && v3_q) begin
      red_q   <= red_w;
      green_q <= green_w;
      blue_q  <= blue_w;
    end
  end

  assign rgb_o.valid = vo_q;
  assign rgb_o.red   = red_q;
  assign rgb_o.green = green_q;
  assign rgb_o.blue  = blue_q;

  // ------------------------------------------------------------- assertions
  a_chan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (lo3_q <= mid_w) && (mid_w <= val3_q))
    else $error("minimum/intermediate/maximum channel order broken");

  a_stage1_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (dist1_q <= 6'(SectorDeg)))
    else $error("hue distance out of range");

  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy2) |=> v1_q && $stable(sec1_q) && $stable(dist1_q)
                        && $stable(sat1_q) && $stable(val1_q))
    else $error("stalled stage one item changed");

endmodule

// ----- test/hsv_to_rgb_converter_tb.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// Self-checking testbench for the pipelined HSV to RGB converter.
// ----------------------------------------------------------------------------
// A directed table covers the extremes, every hue sector, hue wrap-round and
// zero saturation or brightness. A random run of about 1350 colours follows.
// Colours with no typed result go through a local integer predictor, and each
// RGB item that leaves the block is checked against the oldest expected one.
// Both sides idle at random, and the sink holds off once for a long stretch
// so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsvrgb_pkg::*;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_colour_t;

  typedef struct packed {
    hue_t        hue;
    chan_t       saturation;
    chan_t       brightness;
    logic        typed;
    rgb_colour_t colour;
  } hsv_row_t;

  localparam int unsigned NumRows      = 25;
  localparam int unsigned NumRandom    = 1350;
  localparam int unsigned MaxWait      = 12;
  localparam int unsigned StretchLen   = 40;
  localparam int unsigned HoldAtResult = 300;
  localparam int unsigned HoldCycles   = 150;
  localparam int unsigned DrainCycles  = 16;
  localparam int unsigned DrainLimit   = 2000;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned MaxReports   = 10;

  // typed = 1: colour column holds the expected result
  localparam hsv_row_t DirectedRows [NumRows] = '{
    '{9'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{9'd0,   8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{9'd511, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{9'd0,   8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{9'd200, 8'd0,   8'd137, 1'b1, '{8'd137, 8'd137, 8'd137}},
    '{9'd511, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{9'd0,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0  }},
    '{9'd60,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0  }},
    '{9'd120, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0  }},
    '{9'd180, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{9'd240, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{9'd300, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{9'd360, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0  }},
    '{9'd420, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0  }},
    '{9'd480, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0  }},
    '{9'd30,  8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{9'd90,  8'd200, 8'd180, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{9'd150, 8'd128, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{9'd210, 8'd1,   8'd1,   1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{9'd270, 8'd254, 8'd254, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{9'd330, 8'd100, 8'd77,  1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{9'd359, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{9'd511, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{9'd119, 8'd37,  8'd250, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{9'd1,   8'd255, 8'd128, 1'b0, '{8'd0,   8'd0,   8'd0  }}
  };

  localparam hue_t HueEdges [14] = '{
    9'd0, 9'd59, 9'd60, 9'd119, 9'd120, 9'd179, 9'd180,
    9'd239, 9'd240, 9'd299, 9'd300, 9'd359, 9'd360, 9'd511
  };

  logic clk_i;
  logic rst_ni;

  hsvrgb_hsv_if hsv_bus ();
  hsvrgb_rgb_if rgb_bus ();

  hsv_to_rgb_converter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hsv_i  (hsv_bus.sink),
    .rgb_o  (rgb_bus.source)
  );

  rgb_colour_t pending_rgb [$];
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic rgb_colour_t predict_rgb(hue_t hue, chan_t saturation,
                                              chan_t brightness);
    int unsigned angle, offset, spread, s, v, lo, mid;
    sector_e     sector;
    rgb_colour_t colour;
    s      = saturation;
    v      = brightness;
    angle  = hue % HueTurn;
    offset = angle % (2 * SectorDeg);
    spread = (offset >= SectorDeg) ? offset - SectorDeg : SectorDeg - offset;
    lo     = (v * (FullScale - s)) / FullScale;
    mid    = (v * XDenom - v * s * spread) / XDenom;
    sector = sector_e'(angle / SectorDeg);
    case (sector)
      SEC_RED:     colour = '{chan_t'(v),   chan_t'(mid), chan_t'(lo)};
      SEC_YELLOW:  colour = '{chan_t'(mid), chan_t'(v),   chan_t'(lo)};
      SEC_GREEN:   colour = '{chan_t'(lo),  chan_t'(v),   chan_t'(mid)};
      SEC_CYAN:    colour = '{chan_t'(lo),  chan_t'(mid), chan_t'(v)};
      SEC_BLUE:    colour = '{chan_t'(mid), chan_t'(lo),  chan_t'(v)};
      default:     colour = '{chan_t'(v),   chan_t'(lo),  chan_t'(mid)};
    endcase
    return colour;
  endfunction

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // extremes come up more often than a flat draw would give
  function automatic chan_t pick_chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return chan_t'($urandom);
    endcase
  endfunction

  function automatic hue_t pick_hue();
    if ($urandom_range(0, 7) == 0) begin
      return HueEdges[$urandom_range(0, 13)];
    end
    return hue_t'($urandom_range(0, 511));
  endfunction

  // entered just after a rising edge, returns at the edge that takes the item
  task automatic send_hsv(hue_t hue, chan_t saturation, chan_t brightness,
                          rgb_colour_t colour, bit calm);
    int unsigned gap;
    gap = draw_wait(calm);
    repeat (gap) begin
      hsv_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    hsv_bus.valid      <= 1'b1;
    hsv_bus.hue        <= hue;
    hsv_bus.saturation <= saturation;
    hsv_bus.brightness <= brightness;
    do @(posedge clk_i); while (!hsv_bus.ready);
    pending_rgb.push_back(colour);
  endtask

  // sink side: random stalls per item, one long hold-off mid-run
  initial begin
    int unsigned taken, stall;
    bit          calm;
    taken         = 0;
    calm          = 1'b0;
    rgb_bus.ready = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (taken % StretchLen == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      if (taken == HoldAtResult) begin
        repeat (HoldCycles) begin
          rgb_bus.ready <= 1'b0;
          @(posedge clk_i);
        end
      end
      stall = draw_wait(calm);
      repeat (stall) begin
        rgb_bus.ready <= 1'b0;
        @(posedge clk_i);
      end
      rgb_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!rgb_bus.valid);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    rgb_colour_t want, got;
    if (rst_ni && rgb_bus.valid && rgb_bus.ready) begin
      got = '{rgb_bus.red, rgb_bus.green, rgb_bus.blue};
      if (pending_rgb.size() == 0) begin
        if (fault_count < MaxReports) begin
          $display("%0t: unexpected item r=%0d g=%0d b=%0d",
                   $realtime, got.red, got.green, got.blue);
        end
        fault_count++;
      end else begin
        want = pending_rgb.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue) begin
          if (fault_count < MaxReports) begin
            $display("%0t: mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                     $realtime, want.red, want.green, want.blue,
                     got.red, got.green, got.blue);
          end
          fault_count++;
        end
      end
    end
  end

  initial begin
    hsv_row_t    row;
    hue_t        hue;
    chan_t       saturation, brightness;
    rgb_colour_t colour;
    int unsigned waited;
    bit          calm;
    rst_ni             = 1'b0;
    hsv_bus.valid      = 1'b0;
    hsv_bus.hue        = '0;
    hsv_bus.saturation = '0;
    hsv_bus.brightness = '0;
    calm               = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < NumRows; i++) begin
      row    = DirectedRows[i];
      colour = row.typed ? row.colour
                         : predict_rgb(row.hue, row.saturation, row.brightness);
      send_hsv(row.hue, row.saturation, row.brightness, colour, i < 8);
    end

    for (int unsigned i = 0; i < NumRandom; i++) begin
      if (i % StretchLen == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      hue        = pick_hue();
      saturation = pick_chan();
      brightness = pick_chan();
      send_hsv(hue, saturation, brightness,
               predict_rgb(hue, saturation, brightness), calm);
    end
    hsv_bus.valid <= 1'b0;

    waited = 0;
    while (pending_rgb.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_rgb.size() != 0) begin
      $display("%0d predicted items never left the block", pending_rgb.size());
      fault_count++;
    end

    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_if.sv
rtl/hsvrgb_mid_div.sv
rtl/hsv_to_rgb_converter.sv
test/hsv_to_rgb_converter_tb.sv
